// ----- src/trapezoidal_motion_profiler_macros.svh -----
// ----------------------------------------------------------------------------
// Trapezoidal motion profiler assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOIDAL_MOTION_PROFILER_MACROS_SVH
`define TRAPEZOIDAL_MOTION_PROFILER_MACROS_SVH
`ifndef SYNTH
// Assert a property on the rising clock, off while reset is active
`define TMP_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("trapezoidal_motion_profiler: check failed");
// Assert a property on the rising clock, also during reset
`define TMP_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("trapezoidal_motion_profiler: check failed");
`else
`define TMP_ASSERT(name, clk, rst_n, prop)
`define TMP_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ----- src/tmp_pkg.sv -----
// ----------------------------------------------------------------------------
// Trapezoidal motion profiler package
// Sizes, operation codes, state encoding and the step-toward-goal helper.
// ----------------------------------------------------------------------------
package tmp_pkg;

    localparam int NUM_MOTORS = 16;
    localparam int IDX_W      = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int MUL_STEPS  = 24;
    localparam int DIV_STEPS  = 47;
    localparam int CNT_W      = 6;

    localparam logic [1:0] FUNC_SET_TARGET = 2'd0;
    localparam logic [1:0] FUNC_SET_POS    = 2'd1;
    localparam logic [1:0] FUNC_TICK       = 2'd2;

    localparam logic [1:0] STAGE_ACCEL = 2'd0;
    localparam logic [1:0] STAGE_DECEL = 2'd1;
    localparam logic [1:0] STAGE_STOP  = 2'd2;

    localparam logic signed [23:0] V24_MAX = 24'sh7FFFFF;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LOAD = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_FIX  = 8'b0001_0000,
        S_DEC  = 8'b0010_0000,
        S_UPD  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    // Move cur by |step| toward goal, stopping exactly at goal
    function automatic logic signed [23:0] toward(input logic signed [23:0] cur,
                                                  input logic signed [23:0] goal,
                                                  input logic signed [23:0] step);
        logic signed [24:0] mag;
        logic signed [25:0] up;
        logic signed [25:0] dn;
        logic signed [23:0] res;
        mag = step[23] ? (25'sd0 - 25'(step)) : 25'(step);
        up  = 26'(cur) + 26'(mag);
        dn  = 26'(cur) - 26'(mag);
        if (goal == cur) begin
            res = cur;
        end else if (goal > cur) begin
            res = (up > 26'(goal)) ? goal : up[23:0];
        end else begin
            res = (dn < 26'(goal)) ? goal : dn[23:0];
        end
        return res;
    endfunction

endpackage

// ----- src/trapezoidal_motion_profiler.sv -----
// ----------------------------------------------------------------------------
// Trapezoidal motion profiler
// Per-servo trapezoidal velocity profile with parabola-corrected braking.
// ----------------------------------------------------------------------------
// Set-target and set-position items are applied in the idle state. A tick walks the motors
// one at a time: an idle or stopping motor needs only the load state, an accelerating
// motor a load and an update, and a braking motor a load, a bit-serial 24-step
// squaring of the speed, a 47-step restoring divide by twice the remaining distance,
// then a fix, an optional braking step and an update (at zero remaining distance the
// squaring and divide are skipped). The 16 reports then leave in motor order as
// m_axis_tready takes them, the last one flagged by tlast; no new item is taken until the
// final report has gone out.
// ----------------------------------------------------------------------------
`include "trapezoidal_motion_profiler_macros.svh"

module trapezoidal_motion_profiler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: minimum braking speed
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [22:0] i_cfg_data,
    // items in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // motor[3:0], target[27:4], speed_limit[51:28], accel[75:52]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    // position reports out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // motor_out[3:0], position[19:4], moving[20]
    output logic        m_axis_tlast
);

    localparam int N = tmp_pkg::NUM_MOTORS;
    localparam int W = tmp_pkg::IDX_W;

    // stores
    logic signed [23:0] r_pos [N];
    logic signed [23:0] r_dst [N];
    logic signed [23:0] r_mid [N];
    logic signed [23:0] r_spd [N];
    logic signed [23:0] r_lim [N];
    logic signed [23:0] r_acc [N];
    logic [N-1:0]       r_moving;
    logic [22:0]        r_min_down;

    tmp_pkg::t_state r_state, n_state;
    logic [W-1:0]       r_idx;
    logic [tmp_pkg::CNT_W-1:0] r_cnt;

    // working registers of the motor under update
    logic signed [23:0] r_w_cur, r_w_dst, r_w_spd, r_w_acc;
    logic [25:0]        r_den;
    logic               r_neg;
    logic [23:0]        r_mplier;
    logic [46:0]        r_mcand;
    logic [46:0]        r_prod;
    logic [26:0]        r_rem;
    logic [24:0]        r_quo;
    logic               r_ovf;

    // input fields
    logic [1:0]         in_func;
    logic [3:0]         in_motor;
    logic signed [23:0] in_target, in_vel_limit, in_accel;
    assign in_func      = s_axis_tuser;
    assign in_motor     = s_axis_tdata[3:0];
    assign in_target    = s_axis_tdata[27:4];
    assign in_vel_limit = s_axis_tdata[51:28];
    assign in_accel     = s_axis_tdata[75:52];

    logic in_acc;
    logic in_ok;
    logic [W-1:0] in_idx;
    assign s_axis_tready = (r_state == tmp_pkg::S_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_ok    = (32'(in_motor) < N);
    assign in_idx   = W'(in_motor);
    assign o_cfg_ready = 1'b1;

    // set-target arithmetic
    logic signed [24:0] st_diff, st_sum;
    logic               st_small;
    logic signed [23:0] st_ms_mag, st_ac_mag, st_lim, st_acc;
    always_comb begin
        st_diff   = 25'(in_target) - 25'(r_pos[in_idx]);
        st_sum    = 25'(in_target) + 25'(r_pos[in_idx]);
        st_small  = (st_diff >= -25'sd255) && (st_diff <= 25'sd255);
        st_ms_mag = (in_vel_limit == 24'sh800000) ? tmp_pkg::V24_MAX :
                    (in_vel_limit[23] ? -in_vel_limit : in_vel_limit);
        st_ac_mag = (in_accel == 24'sh800000) ? tmp_pkg::V24_MAX :
                    (in_accel[23] ? -in_accel : in_accel);
        st_lim    = st_diff[24] ? -st_ms_mag : st_ms_mag;
        st_acc    = st_diff[24] ? -st_ac_mag : st_ac_mag;
    end

    // phase of the motor under the tick pointer
    logic [1:0]         ld_stage;
    logic signed [24:0] ld_dd;
    logic [24:0]        ld_dd_mag;
    logic [23:0]        ld_spd_mag;
    logic signed [23:0] ld_cur, ld_dst, ld_mid;
    always_comb begin
        ld_cur = r_pos[r_idx];
        ld_dst = r_dst[r_idx];
        ld_mid = r_mid[r_idx];
        if (ld_mid < ld_dst) begin
            ld_stage = (ld_cur < ld_mid) ? tmp_pkg::STAGE_ACCEL :
                       ((ld_cur < ld_dst) ? tmp_pkg::STAGE_DECEL : tmp_pkg::STAGE_STOP);
        end else begin
            ld_stage = (ld_mid < ld_cur) ? tmp_pkg::STAGE_ACCEL :
                       ((ld_dst < ld_cur) ? tmp_pkg::STAGE_DECEL : tmp_pkg::STAGE_STOP);
        end
        ld_dd      = 25'(ld_dst) - 25'(ld_cur);
        ld_dd_mag  = ld_dd[24] ? 25'(-ld_dd) : 25'(ld_dd);
        ld_spd_mag = r_spd[r_idx][23] ? 24'(-25'(r_spd[r_idx])) : 24'(r_spd[r_idx]);
    end

    // divider step
    logic [26:0] dv_rem;
    logic        dv_ge;
    assign dv_rem = {r_rem[25:0], r_prod[46]};
    assign dv_ge  = (dv_rem >= {1'b0, r_den});

    // corrected acceleration
    logic [24:0]        fx_cap, fx_qm, fx_amag;
    logic signed [24:0] fx_corr;
    logic signed [25:0] fx_sum;
    always_comb begin
        fx_cap  = r_neg ? 25'd8388608 : 25'd8388607;
        fx_qm   = (r_ovf || (r_quo > fx_cap)) ? fx_cap : r_quo;
        fx_corr = r_neg ? -$signed(fx_qm) : $signed(fx_qm);
        fx_amag = r_w_acc[23] ? 25'(-25'(r_w_acc)) : 25'(r_w_acc);
        fx_sum  = 26'(r_w_acc) + 26'(fx_corr);
    end

    // braking goal: minimum braking speed with the sign of accel
    logic signed [23:0] dc_goal;
    always_comb begin
        if (r_w_acc > 0) begin
            dc_goal = $signed({1'b0, r_min_down});
        end else if (r_w_acc < 0) begin
            dc_goal = -$signed({1'b0, r_min_down});
        end else begin
            dc_goal = '0;
        end
    end

    // sequencer
    logic last_idx;
    assign last_idx = (32'(r_idx) == N - 1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tmp_pkg::S_IDLE: begin
                if (in_acc && in_func == tmp_pkg::FUNC_TICK) n_state = tmp_pkg::S_LOAD;
            end
            tmp_pkg::S_LOAD: begin
                if (!r_moving[r_idx] || ld_stage == tmp_pkg::STAGE_STOP) begin
                    n_state = last_idx ? tmp_pkg::S_OUT : tmp_pkg::S_LOAD;
                end else if (ld_stage == tmp_pkg::STAGE_ACCEL) begin
                    n_state = tmp_pkg::S_UPD;
                end else begin
                    n_state = (ld_dd == '0) ? tmp_pkg::S_FIX : tmp_pkg::S_MUL;
                end
            end
            tmp_pkg::S_MUL: begin
                if (32'(r_cnt) == tmp_pkg::MUL_STEPS - 1) n_state = tmp_pkg::S_DIV;
            end
            tmp_pkg::S_DIV: begin
                if (32'(r_cnt) == tmp_pkg::DIV_STEPS - 1) n_state = tmp_pkg::S_FIX;
            end
            tmp_pkg::S_FIX: begin
                n_state = (fx_amag <= fx_qm) ? tmp_pkg::S_DEC : tmp_pkg::S_UPD;
            end
            tmp_pkg::S_DEC: n_state = tmp_pkg::S_UPD;
            tmp_pkg::S_UPD: n_state = last_idx ? tmp_pkg::S_OUT : tmp_pkg::S_LOAD;
            tmp_pkg::S_OUT: begin
                if (m_axis_tready && last_idx) n_state = tmp_pkg::S_IDLE;
            end
            default: n_state = tmp_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tmp_pkg::S_IDLE;
            r_idx      <= '0;
            r_cnt      <= '0;
            r_min_down <= 23'd256;
            r_moving   <= '0;
            for (int i = 0; i < N; i++) begin
                r_pos[i] <= '0;
                r_dst[i] <= '0;
                r_mid[i] <= '0;
                r_spd[i] <= '0;
                r_lim[i] <= '0;
                r_acc[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_min_down <= i_cfg_data;
            unique case (r_state)
                tmp_pkg::S_IDLE: begin
                    r_idx <= '0;
                    r_cnt <= '0;
                    // apply set items
                    if (in_acc && in_ok && in_func == tmp_pkg::FUNC_SET_TARGET && !st_small) begin
                        r_dst[in_idx]    <= in_target;
                        r_mid[in_idx]    <= st_sum[24:1];
                        r_lim[in_idx]    <= st_lim;
                        r_acc[in_idx]    <= st_acc;
                        r_moving[in_idx] <= 1'b1;
                    end
                    if (in_acc && in_ok && in_func == tmp_pkg::FUNC_SET_POS) begin
                        r_pos[in_idx] <= in_target;
                        r_dst[in_idx] <= in_target;
                    end
                end
                tmp_pkg::S_LOAD: begin
                    r_cnt <= '0;
                    if (!r_moving[r_idx] || ld_stage == tmp_pkg::STAGE_STOP) begin
                        // stop at target, or skip an idle motor
                        if (r_moving[r_idx]) begin
                            r_moving[r_idx] <= 1'b0;
                            r_pos[r_idx]    <= ld_dst;
                            r_spd[r_idx]    <= '0;
                            r_acc[r_idx]    <= '0;
                            r_lim[r_idx]    <= '0;
                        end
                        r_idx <= last_idx ? '0 : r_idx + 1'b1;
                    end
                end
                tmp_pkg::S_MUL: begin
                    // restart the count for the divide
                    r_cnt <= (32'(r_cnt) == tmp_pkg::MUL_STEPS - 1) ? '0 : r_cnt + 1'b1;
                end
                tmp_pkg::S_DIV: r_cnt <= r_cnt + 1'b1;
                tmp_pkg::S_FIX, tmp_pkg::S_DEC: ;
                tmp_pkg::S_UPD: begin
                    // write back the stepped motor
                    r_pos[r_idx] <= tmp_pkg::toward(r_w_cur, r_w_dst, r_w_spd);
                    r_spd[r_idx] <= r_w_spd;
                    r_acc[r_idx] <= r_w_acc;
                    r_idx <= last_idx ? '0 : r_idx + 1'b1;
                end
                tmp_pkg::S_OUT: begin
                    if (m_axis_tready) r_idx <= last_idx ? '0 : r_idx + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath of the motor under update
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tmp_pkg::S_LOAD: begin
                r_w_cur  <= ld_cur;
                r_w_dst  <= ld_dst;
                r_w_acc  <= r_acc[r_idx];
                r_w_spd  <= (ld_stage == tmp_pkg::STAGE_ACCEL) ?
                            tmp_pkg::toward(r_spd[r_idx], r_lim[r_idx], r_acc[r_idx]) :
                            r_spd[r_idx];
                r_den    <= {ld_dd_mag, 1'b0};
                r_neg    <= ld_dd[24];
                r_mplier <= ld_spd_mag;
                r_mcand  <= 47'(ld_spd_mag);
                r_prod   <= '0;
                r_rem    <= '0;
                r_quo    <= '0;
                r_ovf    <= 1'b0;
            end
            tmp_pkg::S_MUL: begin
                // shift-add square of the speed magnitude
                if (r_mplier[0]) r_prod <= r_prod + r_mcand;
                r_mcand  <= {r_mcand[45:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[23:1]};
            end
            tmp_pkg::S_DIV: begin
                // restoring divide, one quotient bit per cycle
                r_prod <= {r_prod[45:0], 1'b0};
                r_rem  <= dv_ge ? (dv_rem - {1'b0, r_den}) : dv_rem;
                r_quo  <= {r_quo[23:0], dv_ge};
                r_ovf  <= r_ovf | r_quo[24];
            end
            tmp_pkg::S_FIX: begin
                // blend accel with the correction only when it is not weaker
                if (fx_amag <= fx_qm) r_w_acc <= fx_sum[24:1];
            end
            tmp_pkg::S_DEC: begin
                r_w_spd <= tmp_pkg::toward(r_w_spd, dc_goal, r_w_acc);
            end
            default: ;
        endcase
    end

    // position report
    logic signed [23:0] out_pos;
    logic [15:0]        out_sat;
    always_comb begin
        out_pos = r_pos[r_idx];
        if (!out_pos[23] && out_pos[22:15] != '0) begin
            out_sat = 16'h7FFF;
        end else if (out_pos[23] && out_pos[22:15] != 8'hFF) begin
            out_sat = 16'h8000;
        end else begin
            out_sat = out_pos[15:0];
        end
    end

    assign m_axis_tvalid = (r_state == tmp_pkg::S_OUT);
    assign m_axis_tdata  = {3'd0, r_moving[r_idx], out_sat, 4'(r_idx)};
    assign m_axis_tlast  = last_idx;

    // checks
    `TMP_ASSERT(a_out_blocks_in, i_clk, i_rst_n, m_axis_tvalid |-> !s_axis_tready)
    `TMP_ASSERT(a_last_frees_in, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    `TMP_ASSERT(a_div_bounded, i_clk, i_rst_n, (r_state == tmp_pkg::S_DIV) |-> (32'(r_cnt) < tmp_pkg::DIV_STEPS))
    `TMP_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == tmp_pkg::S_IDLE))

endmodule
